[rtl/sams_pkg.sv]
`default_nettype none

package sams_pkg;

    localparam int DUTY_W = 15;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TICK = 2'd0;
    localparam t_kind KIND_CMD  = 2'd1;
    localparam t_kind KIND_TILT = 2'd2;

    typedef logic [1:0] t_slope;
    localparam t_slope SLOPE_FLAT = 2'd0;
    localparam t_slope SLOPE_UP   = 2'd1;
    localparam t_slope SLOPE_DOWN = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_UPHILL   = 2'd0;
    localparam t_cfg_idx CFG_DOWNHILL = 2'd1;
    localparam t_cfg_idx CFG_IGNORE   = 2'd2;
    localparam t_cfg_idx CFG_CRUISE   = 2'd3;

    localparam logic [7:0] CODE_REVERSE = 8'd0;
    localparam logic [7:0] CODE_BRAKE   = 8'd1;
    localparam logic [7:0] CODE_FWD_A   = 8'd2;
    localparam logic [7:0] CODE_FWD_B   = 8'd3;

    localparam logic [4:0] STEP_START = 5'd5;
    localparam logic [4:0] STEP_BACK  = 5'd10;
    localparam logic [4:0] STEP_HOLD  = 5'd15;
    localparam logic [4:0] STEP_END   = 5'd20;

    localparam logic [DUTY_W-1:0] DUTY_MAX       = 15'd20000;
    localparam logic [DUTY_W-1:0] DUTY_INIT      = 15'd3600;
    localparam logic [DUTY_W-1:0] DUTY_REVERSE   = 15'd3220;
    localparam logic [DUTY_W-1:0] DUTY_BRAKE     = 15'd3400;
    localparam logic [DUTY_W-1:0] DUTY_HOLD      = 15'd3720;
    localparam logic [DUTY_W-1:0] DUTY_RESUME    = 15'd3780;
    localparam logic [DUTY_W-1:0] DUTY_UP_BOOST  = 15'd3860;
    localparam logic [DUTY_W-1:0] DUTY_DOWN_FAST = 15'd3660;
    localparam logic [DUTY_W-1:0] DUTY_DOWN_MED  = 15'd3740;

    typedef struct packed {
        t_slope            slope;
        logic [7:0]        target;
        logic [9:0]        measured;
        logic [DUTY_W-1:0] duty;
    } t_reg_in;

endpackage

`default_nettype wire

[rtl/sams_if.sv]
`default_nettype none

interface sams_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [9:0]         revolutions;
    logic [7:0]         speed_code;
    logic signed [15:0] tilt;

    modport source (output valid, kind, revolutions, speed_code, tilt, input ready);
    modport sink   (input valid, kind, revolutions, speed_code, tilt, output ready);
endinterface

interface sams_out_if;
    logic        valid;
    logic        ready;
    logic        drive_written;
    logic [14:0] drive_duty;
    logic [7:0]  target_speed;
    logic [9:0]  measured_speed;
    logic [1:0]  slope;
    logic        reversing;

    modport source (output valid, drive_written, drive_duty, target_speed, measured_speed,
                    slope, reversing, input ready);
    modport sink   (input valid, drive_written, drive_duty, target_speed, measured_speed,
                    slope, reversing, output ready);
endinterface

interface sams_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/sams_regulator.sv]
`default_nettype none

module sams_regulator
    import sams_pkg::*;
(
    input  t_reg_in           i_req,
    output logic [DUTY_W-1:0] o_duty
);

    logic signed [11:0]     d;
    logic signed [7:0]      delta;
    logic                   set_en;
    logic [DUTY_W-1:0]      set_val;
    logic signed [DUTY_W+1:0] sum;

    always_comb begin
        if (i_req.slope == SLOPE_DOWN) begin
            d = $signed({2'b00, i_req.measured}) - $signed({4'b0000, i_req.target});
        end else begin
            d = $signed({4'b0000, i_req.target}) - $signed({2'b00, i_req.measured});
        end
    end

    always_comb begin
        set_en  = 1'b0;
        set_val = DUTY_INIT;
        delta   = 8'sd0;
        if (i_req.slope == SLOPE_DOWN) begin
            priority if (d > 12'sd8) begin
                set_en  = 1'b1;
                set_val = DUTY_DOWN_FAST;
            end else if (d > 12'sd4) begin
                set_en  = 1'b1;
                set_val = DUTY_DOWN_MED;
            end else if (d == 12'sd4) begin
                delta = -8'sd60;
            end else if (d > 12'sd1) begin
                delta = -8'sd2;
            end else if (d < 12'sd0) begin
                delta = 8'sd1;
            end else begin
                delta = 8'sd0;
            end
        end else begin
            priority if (d > 12'sd5) begin
                if (i_req.slope == SLOPE_UP) begin
                    set_en  = 1'b1;
                    set_val = DUTY_UP_BOOST;
                end else begin
                    delta = 8'sd100;
                end
            end else if (d >= 12'sd4) begin
                delta = 8'sd60;
            end else if (d > 12'sd1) begin
                delta = 8'sd2;
            end else if (d < -12'sd2) begin
                delta = -8'sd10;
            end else if (d < 12'sd0) begin
                delta = -8'sd2;
            end else begin
                delta = 8'sd0;
            end
        end
    end

    assign sum = $signed({2'b00, i_req.duty}) + (DUTY_W+2)'(delta);

    always_comb begin
        if (set_en) begin
            o_duty = set_val;
        end else if (sum < 0) begin
            o_duty = '0;
        end else if (sum > $signed({2'b00, DUTY_MAX})) begin
            o_duty = DUTY_MAX;
        end else begin
            o_duty = sum[DUTY_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/slope_aware_motor_speed_controller.sv]
// Throughput: one request per cycle while the output is not stalled; input register, update logic, result register.
// A waiting result holds one more request in the input register, then the input stalls.
// Reset (synchronous, active low): duty 3600, target 0, flat, not reversing,
// registers at 46 / -150 / 0 / 6, both pipeline stages empty.
`default_nettype none

module slope_aware_motor_speed_controller
    import sams_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    sams_in_if.sink     i_in,
    sams_out_if.source  o_out,
    sams_cfg_if.sink    i_cfg
);

    // configuration
    logic signed [15:0] r_up_thr;
    logic signed [15:0] r_down_thr;
    logic               r_ignore_tilt;
    logic [7:0]         r_cruise;

    // input stage
    logic               r_iv;
    t_kind              r_kind;
    logic [9:0]         r_revs;
    logic [7:0]         r_code;
    logic signed [15:0] r_tilt;

    // state
    logic [DUTY_W-1:0]  r_duty_setting, n_duty_setting;
    logic [7:0]         r_required, n_required;
    t_slope             r_slope, n_slope;
    logic               r_rev_active, n_rev_active;
    logic [4:0]         r_rev_step, n_rev_step;
    logic [7:0]         r_last_cmd, n_last_cmd;
    logic [9:0]         r_last_meas, n_last_meas;

    // result stage
    logic               r_ov;
    logic               r_written, n_written;
    logic [DUTY_W-1:0]  r_duty, n_duty;

    logic               out_free;
    logic               fire;
    logic               in_acc;
    t_reg_in            reg_req;
    logic [DUTY_W-1:0]  reg_duty;

    assign out_free    = !r_ov || o_out.ready;
    assign fire        = r_iv && out_free;
    assign i_in.ready  = !r_iv || out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign reg_req.slope    = r_slope;
    assign reg_req.target   = r_required;
    assign reg_req.measured = r_revs;
    assign reg_req.duty     = r_duty_setting;

    sams_regulator u_reg (
        .i_req  (reg_req),
        .o_duty (reg_duty)
    );

    always_comb begin
        n_duty_setting = r_duty_setting;
        n_required     = r_required;
        n_slope        = r_slope;
        n_rev_active   = r_rev_active;
        n_rev_step     = r_rev_step;
        n_last_cmd     = r_last_cmd;
        n_last_meas    = r_last_meas;
        n_written      = 1'b0;
        n_duty         = '0;
        unique case (r_kind)
            KIND_TICK: begin
                n_last_meas = r_revs;
                if (r_required != 8'd0) begin
                    n_duty_setting = reg_duty;
                    n_written      = 1'b1;
                    n_duty         = reg_duty;
                end
            end
            KIND_CMD: begin
                if (!r_rev_active && r_code != r_last_cmd) begin
                    n_last_cmd = r_code;
                    if (r_code == CODE_REVERSE) begin
                        n_required   = 8'd0;
                        n_rev_active = 1'b1;
                        n_rev_step   = STEP_START;
                    end else if (r_code == CODE_BRAKE) begin
                        n_required     = 8'd0;
                        n_rev_active   = 1'b0;
                        n_written      = 1'b1;
                        n_duty         = (r_last_cmd == CODE_REVERSE) ? DUTY_HOLD : DUTY_BRAKE;
                        n_duty_setting = DUTY_RESUME;
                    end else if (r_code == CODE_FWD_A || r_code == CODE_FWD_B) begin
                        n_required   = r_cruise;
                        n_rev_active = 1'b0;
                    end
                end
            end
            KIND_TILT: begin
                if (r_rev_active) begin
                    n_rev_step = r_rev_step + 5'd1;
                    if (r_rev_step == STEP_START || r_rev_step == STEP_HOLD) begin
                        n_written = 1'b1;
                        n_duty    = DUTY_INIT;
                    end else if (r_rev_step == STEP_BACK) begin
                        n_written = 1'b1;
                        n_duty    = DUTY_REVERSE;
                    end else if (r_rev_step > STEP_END) begin
                        n_written      = 1'b1;
                        n_duty         = DUTY_REVERSE;
                        n_rev_active   = 1'b0;
                        n_duty_setting = DUTY_RESUME;
                    end
                end
                if (r_ignore_tilt) begin
                    n_slope = SLOPE_FLAT;
                end else if (r_tilt > r_up_thr) begin
                    n_slope = SLOPE_UP;
                end else if (r_tilt < r_down_thr) begin
                    n_slope = SLOPE_DOWN;
                end else begin
                    n_slope = SLOPE_FLAT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_thr      <= 16'sd46;
            r_down_thr    <= -16'sd150;
            r_ignore_tilt <= 1'b0;
            r_cruise      <= 8'd6;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_UPHILL:   r_up_thr      <= i_cfg.data;
                CFG_DOWNHILL: r_down_thr    <= i_cfg.data;
                CFG_IGNORE:   r_ignore_tilt <= i_cfg.data[0];
                CFG_CRUISE:   r_cruise      <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (in_acc) begin
            r_iv <= 1'b1;
        end else if (fire) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_in.kind;
            r_revs <= i_in.revolutions;
            r_code <= i_in.speed_code;
            r_tilt <= i_in.tilt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_setting <= DUTY_INIT;
            r_required     <= 8'd0;
            r_slope        <= SLOPE_FLAT;
            r_rev_active   <= 1'b0;
            r_rev_step     <= 5'd0;
            r_last_cmd     <= 8'd0;
            r_last_meas    <= 10'd0;
        end else if (fire) begin
            r_duty_setting <= n_duty_setting;
            r_required     <= n_required;
            r_slope        <= n_slope;
            r_rev_active   <= n_rev_active;
            r_rev_step     <= n_rev_step;
            r_last_cmd     <= n_last_cmd;
            r_last_meas    <= n_last_meas;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fire) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_written <= n_written;
            r_duty    <= n_duty;
        end
    end

    // status fields follow the state registers, which only move when a result loads
    assign o_out.valid          = r_ov;
    assign o_out.drive_written  = r_written;
    assign o_out.drive_duty     = r_duty;
    assign o_out.target_speed   = r_required;
    assign o_out.measured_speed = r_last_meas;
    assign o_out.slope          = r_slope;
    assign o_out.reversing      = r_rev_active;

endmodule

`default_nettype wire

[bench/slope_aware_motor_speed_controller_test.sv]
`timescale 1ns / 100ps

module slope_aware_motor_speed_controller_test
    import sams_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_COUNT   = 420;

    localparam t_kind      KIND_SPARE = 2'd3;
    localparam logic [7:0] CODE_IDLE  = 8'd255;

    typedef struct {
        t_kind              kind;
        logic [9:0]         revolutions;
        logic [7:0]         speed_code;
        logic signed [15:0] tilt;
    } t_request;

    typedef struct {
        logic        written;
        logic [14:0] duty;
        logic [7:0]  target;
        logic [9:0]  measured;
        t_slope      slope;
        logic        reversing;
    } t_drive_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sams_in_if  in_if();
    sams_out_if out_if();
    sams_cfg_if cfg_if();

    slope_aware_motor_speed_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // regulator state as the block should hold it
    int                 duty_now;
    logic [7:0]         target_rps;
    logic [9:0]         measured_rps;
    t_slope             slope_now;
    logic               reversing_now;
    logic [4:0]         reverse_phase;
    logic [7:0]         last_code;
    logic signed [15:0] uphill_limit;
    logic signed [15:0] downhill_limit;
    logic               tilt_ignored;
    logic [7:0]         cruise_rps;

    t_drive_result expected_drive[$];
    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int requests_sent = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function void reset_regulator();
        duty_now       = int'(DUTY_INIT);
        target_rps     = '0;
        measured_rps   = '0;
        slope_now      = SLOPE_FLAT;
        reversing_now  = 1'b0;
        reverse_phase  = '0;
        last_code      = CODE_REVERSE;
        uphill_limit   = 16'sd46;
        downhill_limit = -16'sd150;
        tilt_ignored   = 1'b0;
        cruise_rps     = 8'd6;
    endfunction

    function void adjust_duty();
        int d;
        if (slope_now == SLOPE_DOWN) begin
            d = int'(measured_rps) - int'(target_rps);
            if (d > 8) duty_now = int'(DUTY_DOWN_FAST);
            else if (d > 4) duty_now = int'(DUTY_DOWN_MED);
            else if (d == 4) duty_now -= 60;
            else if (d > 1) duty_now -= 2;
            else if (d < 0) duty_now += 1;
        end else begin
            d = int'(target_rps) - int'(measured_rps);
            if (d > 5) duty_now = (slope_now == SLOPE_UP) ? int'(DUTY_UP_BOOST) : duty_now + 100;
            else if (d >= 4) duty_now += 60;
            else if (d > 1) duty_now += 2;
            else if (d < -2) duty_now -= 10;
            else if (d < 0) duty_now -= 2;
        end
        if (duty_now < 0) duty_now = 0;
        else if (duty_now > int'(DUTY_MAX)) duty_now = int'(DUTY_MAX);
    endfunction

    function t_drive_result predict_drive(t_request rq);
        t_drive_result r;
        r.written = 1'b0;
        r.duty    = '0;
        case (rq.kind)
            KIND_TICK: begin
                measured_rps = rq.revolutions;
                if (target_rps != 0) begin
                    adjust_duty();
                    r.written = 1'b1;
                    r.duty    = duty_now[14:0];
                end
            end
            KIND_CMD: begin
                if (!reversing_now && rq.speed_code != last_code) begin
                    case (rq.speed_code)
                        CODE_REVERSE: begin
                            target_rps    = '0;
                            reversing_now = 1'b1;
                            reverse_phase = STEP_START;
                        end
                        CODE_BRAKE: begin
                            target_rps    = '0;
                            reversing_now = 1'b0;
                            r.written     = 1'b1;
                            r.duty        = (last_code == CODE_REVERSE) ? DUTY_HOLD : DUTY_BRAKE;
                            duty_now      = int'(DUTY_RESUME);
                        end
                        CODE_FWD_A, CODE_FWD_B: begin
                            target_rps    = cruise_rps;
                            reversing_now = 1'b0;
                        end
                        default: ;
                    endcase
                    last_code = rq.speed_code;
                end
            end
            KIND_TILT: begin
                if (reversing_now) begin
                    if (reverse_phase == STEP_START || reverse_phase == STEP_HOLD) begin
                        r.written = 1'b1;
                        r.duty    = DUTY_INIT;
                    end else if (reverse_phase == STEP_BACK) begin
                        r.written = 1'b1;
                        r.duty    = DUTY_REVERSE;
                    end else if (reverse_phase > STEP_END) begin
                        r.written     = 1'b1;
                        r.duty        = DUTY_REVERSE;
                        reversing_now = 1'b0;
                        duty_now      = int'(DUTY_RESUME);
                    end
                    reverse_phase = reverse_phase + 5'd1;
                end
                if (tilt_ignored) slope_now = SLOPE_FLAT;
                else if (rq.tilt > uphill_limit) slope_now = SLOPE_UP;
                else if (rq.tilt < downhill_limit) slope_now = SLOPE_DOWN;
                else slope_now = SLOPE_FLAT;
            end
            default: ;
        endcase
        r.target    = target_rps;
        r.measured  = measured_rps;
        r.slope     = slope_now;
        r.reversing = reversing_now;
        return r;
    endfunction

    function t_request make_request(t_kind kind, logic [9:0] revs, logic [7:0] code,
                                    logic signed [15:0] tilt);
        t_request rq;
        rq.kind        = kind;
        rq.revolutions = revs;
        rq.speed_code  = code;
        rq.tilt        = tilt;
        return rq;
    endfunction

    function t_request tick(int revs);
        return make_request(KIND_TICK, 10'(revs), 8'($urandom_range(255)),
                            16'($urandom_range(65535)));
    endfunction

    function t_request command(logic [7:0] code);
        return make_request(KIND_CMD, 10'($urandom_range(1023)), code,
                            16'($urandom_range(65535)));
    endfunction

    function t_request tilt_sample(int tilt);
        return make_request(KIND_TILT, 10'($urandom_range(1023)), 8'($urandom_range(255)),
                            16'(tilt));
    endfunction

    task automatic send_request(input t_request rq);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
        end
        @(negedge i_clk);
        in_if.valid       = 1'b1;
        in_if.kind        = rq.kind;
        in_if.revolutions = rq.revolutions;
        in_if.speed_code  = rq.speed_code;
        in_if.tilt        = rq.tilt;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_drive.push_back(predict_drive(rq));
        requests_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_drive.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_UPHILL:   uphill_limit   = value;
            CFG_DOWNHILL: downhill_limit = value;
            CFG_IGNORE:   tilt_ignored   = value[0];
            CFG_CRUISE:   cruise_rps     = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic apply_config(input int up, input int down, input bit ignore_bit,
                                input int cruise);
        drain();
        write_reg(CFG_UPHILL, 16'(up));
        write_reg(CFG_DOWNHILL, 16'(down));
        write_reg(CFG_IGNORE, 16'(ignore_bit));
        write_reg(CFG_CRUISE, 16'(cruise));
    endtask

    task automatic test_reset_state();
        send_request(tick(0));
        send_request(make_request(KIND_SPARE, 10'd1023, 8'd255, -16'sd1));
        send_request(tick(1023));
        send_request(tilt_sample(0));
    endtask

    task automatic test_speed_commands();
        send_request(command(CODE_BRAKE));
        send_request(command(CODE_BRAKE));
        send_request(command(CODE_IDLE));
        send_request(command(CODE_FWD_A));
        send_request(command(CODE_FWD_B));
        send_request(command(CODE_BRAKE));
        send_request(command(CODE_FWD_A));
    endtask

    task automatic test_regulation();
        send_request(tilt_sample(0));
        send_request(tick(0));
        send_request(tick(2));
        send_request(tick(4));
        send_request(tick(5));
        send_request(tick(7));
        send_request(tick(9));
        send_request(tilt_sample(32767));
        send_request(tick(0));
        send_request(tick(3));
        send_request(tilt_sample(-32768));
        send_request(tick(15));
        send_request(tick(11));
        send_request(tick(10));
        send_request(tick(8));
        send_request(tick(6));
        send_request(tick(5));
    endtask

    task automatic test_reverse_sequence();
        send_request(command(CODE_REVERSE));
        send_request(command(CODE_FWD_A));
        for (int i = 0; i < 17; i++) begin
            send_request(tilt_sample((i % 2) ? 32767 : -32768));
        end
        send_request(command(CODE_REVERSE));
        send_request(command(CODE_BRAKE));
    endtask

    task automatic test_register_extremes();
        apply_config(32767, -32768, 1'b0, 0);
        send_request(tilt_sample(32767));
        send_request(tilt_sample(-32768));
        send_request(command(CODE_FWD_B));
        send_request(tick(0));
        apply_config(-32768, 32767, 1'b0, 255);
        send_request(tilt_sample(-32768));
        send_request(tilt_sample(0));
        send_request(command(CODE_FWD_A));
        send_request(tick(255));
        apply_config(-32768, 32767, 1'b1, 6);
        send_request(tilt_sample(-32768));
        send_request(tilt_sample(32767));
        send_request(command(CODE_BRAKE));
    endtask

    // drive up to the ceiling, then down to the floor
    task automatic test_duty_limits();
        apply_config(46, -150, 1'b0, 255);
        send_request(command(CODE_FWD_A));
        send_request(tilt_sample(0));
        repeat (175) send_request(tick(int'($urandom_range(249))));
        send_request(command(CODE_BRAKE));
        send_request(command(CODE_FWD_B));
        repeat (400) send_request(tick(int'($urandom_range(1023, 258))));
    endtask

    task automatic random_config();
        int up;
        int down;
        int cruise;
        case ($urandom_range(3))
            0:       up = 32767;
            1:       up = -32768;
            default: up = int'($urandom_range(600)) - 300;
        endcase
        case ($urandom_range(3))
            0:       down = -32768;
            1:       down = 32767;
            default: down = int'($urandom_range(600)) - 300;
        endcase
        cruise = ($urandom_range(3) == 0) ? int'($urandom_range(255))
                                          : int'($urandom_range(30, 2));
        apply_config(up, down, $urandom_range(3) == 0, cruise);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        t_request rq;
        int start;
        int pick;
        int rev;
        int t;
        bit paused;
        random_config();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start  = requests_sent;
        paused = 1'b0;
        while (requests_sent - start < count) begin
            if ((!paused && requests_sent - start >= count / 2) || $urandom_range(199) == 0) begin
                paused = 1'b1;
                drain();
            end
            pick = int'($urandom_range(99));
            rq = make_request(KIND_TICK, 10'($urandom_range(1023)), 8'($urandom_range(255)),
                              16'($urandom_range(65535)));
            if (pick < 45) begin
                if ($urandom_range(9) != 0) begin
                    rev = int'(target_rps) + int'($urandom_range(24)) - 12;
                    if (rev < 0) rev = 0;
                    rq.revolutions = 10'(rev);
                end
                send_request(rq);
            end else if (pick < 65) begin
                rq.kind = KIND_TILT;
                if ($urandom_range(3) != 0) begin
                    t = ($urandom_range(1) ? int'(uphill_limit) : int'(downhill_limit))
                        + int'($urandom_range(4)) - 2;
                    rq.tilt = 16'(t);
                end
                send_request(rq);
            end else if (pick < 80) begin
                send_request(command($urandom_range(1) ? CODE_FWD_A : CODE_FWD_B));
            end else if (pick < 86) begin
                send_request(command(CODE_BRAKE));
            end else if (pick < 92) begin
                send_request(command(CODE_REVERSE));
                repeat ($urandom_range(20, 14))
                    send_request(tilt_sample(int'($urandom_range(65535))));
            end else begin
                if ($urandom_range(1)) begin
                    rq.kind = KIND_SPARE;
                end else begin
                    rq.kind = KIND_CMD;
                end
                send_request(rq);
            end
        end
    endtask

    always @(negedge i_clk) begin
        out_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_drive_result want;
        if (out_if.valid && out_if.ready) begin
            if (expected_drive.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: drive result with no request pending: wr %0b duty %0d",
                             $time, out_if.drive_written, out_if.drive_duty);
            end else begin
                want = expected_drive.pop_front();
                if (out_if.drive_written !== want.written || out_if.drive_duty !== want.duty ||
                    out_if.target_speed !== want.target ||
                    out_if.measured_speed !== want.measured ||
                    out_if.slope !== want.slope || out_if.reversing !== want.reversing) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: drive mismatch", $time);
                        $display("  expected wr %0b duty %0d target %0d meas %0d slope %0d rev %0b",
                                 want.written, want.duty, want.target, want.measured,
                                 want.slope, want.reversing);
                        $display("  actual   wr %0b duty %0d target %0d meas %0d slope %0d rev %0b",
                                 out_if.drive_written, out_if.drive_duty, out_if.target_speed,
                                 out_if.measured_speed, out_if.slope, out_if.reversing);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** slope_aware_motor_speed_controller: FAILED **");
        $finish;
    end

    initial begin
        in_if.valid       = 1'b0;
        in_if.kind        = KIND_TICK;
        in_if.revolutions = '0;
        in_if.speed_code  = '0;
        in_if.tilt        = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_UPHILL;
        cfg_if.data       = '0;
        reset_regulator();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 75;
        test_reset_state();
        test_speed_commands();
        test_regulation();
        test_reverse_sequence();
        test_register_extremes();

        send_idle_pct = 75;
        recv_idle_pct = 24;
        test_duty_limits();

        test_random_traffic(24, 75, RANDOM_COUNT);
        test_random_traffic(75, 24, RANDOM_COUNT);
        test_random_traffic(0, 0, RANDOM_COUNT);

        drain();
        if (mismatches == 0 && expected_drive.size() == 0) begin
            $display("** slope_aware_motor_speed_controller: PASSED **");
        end else begin
            $display("** slope_aware_motor_speed_controller: FAILED **");
        end
        $finish;
    end

endmodule
